// File: hdl/sdfr_pkg.sv
// ----------------------------------------------------------------------------
// sdfr_pkg: shared types and constants of the depthwise FIR bank
// Request codes, the control word that travels from the front queue to the
// execution pipeline, and the fixed formats of weights and samples.
// ----------------------------------------------------------------------------
package sdfr_pkg;

  // Default configuration of the bank
  localparam int CHANNELS_DEF    = 512;
  localparam int TAPS_DEF        = 11;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed formats: weights are Q2.13, products carry 13 extra fraction bits
  localparam int WEIGHT_BITS = 16;
  localparam int FRAC_SHIFT  = 13;

  // Field widths of an input item
  localparam int CH_W  = 9;
  localparam int TAP_W = 4;

  // Front queue depth and adder-tree group size of the back pipeline
  localparam int QUEUE_DEPTH = 4;
  localparam int GROUP_SIZE  = 8;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    req_t              req;
    logic [CH_W-1:0]   channel;
    logic [TAP_W-1:0]  tap;
  } item_ctl_t;

endpackage

// File: hdl/sdfr_ram.sv
// ----------------------------------------------------------------------------
// sdfr_ram: generic simple dual-port RAM
// One write port and one read port, read data registered; the read data
// holds while the read enable is low.
// ----------------------------------------------------------------------------
module sdfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port, returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/sdfr_front.sv
// ----------------------------------------------------------------------------
// sdfr_front: input classification and item queue
// Accepts items, drops those with an out-of-range channel or, for loads, an
// out-of-range tap, and queues the rest for the execution pipeline.
// ----------------------------------------------------------------------------
module sdfr_front import sdfr_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int TAPS        = TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int DATA_W = (SAMPLE_BITS > WEIGHT_BITS) ? SAMPLE_BITS : WEIGHT_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [CH_W-1:0]               in_chan,
  input  logic [TAP_W-1:0]              in_tap,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  input  logic signed [WEIGHT_BITS-1:0] in_weight_value,
  input  logic                          clearing,
  output logic                          q_valid,
  input  logic                          q_pop,
  output item_ctl_t                     q_ctl,
  output logic [DATA_W-1:0]             q_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_ctl_t         ctl_mem_r  [QUEUE_DEPTH];
  logic [DATA_W-1:0] data_mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  req_t              req;
  logic              keep;
  logic              push;
  logic              pop;
  item_ctl_t         push_ctl;
  logic [DATA_W-1:0] push_data;

  // Classify the incoming item
  always_comb begin
    req       = req_t'(in_req_type);
    keep      = (32'(in_chan) < CHANNELS) &&
                ((req == REQ_SAMPLE) || (32'(in_tap) < TAPS));
    in_ready  = (cnt_r != CNT_W'(QUEUE_DEPTH)) && !clearing;
    push      = in_valid && in_ready && keep;
    pop       = q_pop && (cnt_r != '0);
    push_ctl  = '{req: req, channel: in_chan, tap: in_tap};
    if (req == REQ_LOAD) begin
      push_data = DATA_W'($unsigned(in_weight_value));
    end else begin
      push_data = DATA_W'($unsigned(in_sample_value));
    end
  end

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the item payload
  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem_r[wr_ptr_r]  <= push_ctl;
      data_mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_ctl   = ctl_mem_r[rd_ptr_r];
  assign q_data  = data_mem_r[rd_ptr_r];

endmodule

// File: hdl/sdfr_back.sv
// ----------------------------------------------------------------------------
// sdfr_back: execution pipeline of the FIR bank
// Writes loaded weights, reads weight lanes and the history row of a
// sample's channel, multiplies, sums in a two-level registered tree, adds
// the residual, rounds and saturates. Clears the history after reset.
// ----------------------------------------------------------------------------
module sdfr_back import sdfr_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int TAPS        = TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int DATA_W = (SAMPLE_BITS > WEIGHT_BITS) ? SAMPLE_BITS : WEIGHT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  output logic                   clearing,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  item_ctl_t              q_ctl,
  input  logic [DATA_W-1:0]      q_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_filtered_value,
  output logic [CH_W-1:0]        out_chan,
  output logic                   out_saturated
);

  localparam int HIST   = TAPS - 1;
  localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ROW_W  = HIST * SAMPLE_BITS;
  localparam int PW     = SAMPLE_BITS + WEIGHT_BITS;
  localparam int NGRP   = (TAPS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PAD    = NGRP * GROUP_SIZE;
  localparam int GW     = PW + $clog2(GROUP_SIZE);
  localparam int ACC_W  = SAMPLE_BITS + WEIGHT_BITS + $clog2(TAPS + 1) + 1;
  localparam int QW     = ACC_W - FRAC_SHIFT;
  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(64'sd1 <<< (FRAC_SHIFT - 1));
  localparam logic signed [QW-1:0]    QMAX  =
    QW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [QW-1:0]    QMIN  = ~QMAX;

  // Clearing pass
  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;

  // Pipeline control
  logic          adv;
  logic          pop;
  logic          pop_sample;
  logic          pop_load;
  logic [AW-1:0] q_addr;

  // Memories
  logic [TAPS-1:0]        w_we;
  logic [WEIGHT_BITS-1:0] w_rdata [TAPS];
  logic                   h_we;
  logic [AW-1:0]          h_waddr;
  logic [ROW_W-1:0]       h_wdata;
  logic [ROW_W-1:0]       h_rdata;

  // Read stage
  logic                   s2_valid_r;
  logic [CH_W-1:0]        s2_ch_r;
  logic [SAMPLE_BITS-1:0] s2_x_r;
  logic [HIST-1:0][SAMPLE_BITS-1:0] row_cur;
  logic [HIST-1:0][SAMPLE_BITS-1:0] new_row;
  logic signed [PW-1:0]   prod_nxt [TAPS];

  // Last history write, forwarded to a same-channel sample right behind it
  logic                   fwd_valid_r;
  logic [CH_W-1:0]        fwd_ch_r;
  logic [HIST-1:0][SAMPLE_BITS-1:0] fwd_row_r;

  // Product stage
  logic                   s3_valid_r;
  logic [CH_W-1:0]        s3_ch_r;
  logic [SAMPLE_BITS-1:0] s3_x_r;
  logic signed [PW-1:0]   prod_r [TAPS];
  logic signed [GW-1:0]   grp_nxt [NGRP];

  // Group-sum stage
  logic                   s4_valid_r;
  logic [CH_W-1:0]        s4_ch_r;
  logic [SAMPLE_BITS-1:0] s4_x_r;
  logic signed [GW-1:0]   grp_r [NGRP];
  logic [SAMPLE_BITS-1:0] res_nxt;
  logic                   sat_nxt;

  // Output register
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_val_r;
  logic [CH_W-1:0]        out_ch_r;
  logic                   out_sat_r;

  // Sweep the history memory to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == AW'(CHANNELS - 1)) begin
        clr_active_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  assign clearing = clr_active_r;

  // Advance the whole pipeline whenever the output slot frees
  always_comb begin
    adv        = !out_valid_r || out_ready;
    pop        = adv && q_valid && !clr_active_r;
    pop_sample = pop && (q_ctl.req == REQ_SAMPLE);
    pop_load   = pop && (q_ctl.req == REQ_LOAD);
    q_addr     = AW'(q_ctl.channel);
  end

  assign q_pop = pop;

  // One weight memory per tap lane
  for (genvar k = 0; k < TAPS; k++) begin : g_wlane
    assign w_we[k] = pop_load && (32'(q_ctl.tap) == k);

    sdfr_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (CHANNELS)
    ) u_wram (
      .clk   (clk),
      .we    (w_we[k]),
      .waddr (q_addr),
      .wdata (q_data[WEIGHT_BITS-1:0]),
      .re    (pop_sample),
      .raddr (q_addr),
      .rdata (w_rdata[k])
    );
  end

  // History memory, one row of past samples per channel
  sdfr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CHANNELS)
  ) u_hram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (pop_sample),
    .raddr (q_addr),
    .rdata (h_rdata)
  );

  // Read stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= pop_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ch_r <= q_ctl.channel;
      s2_x_r  <= q_data[SAMPLE_BITS-1:0];
    end
  end

  // Select the current history row and shift the new sample in
  always_comb begin
    if (fwd_valid_r && (fwd_ch_r == s2_ch_r)) begin
      row_cur = fwd_row_r;
    end else begin
      row_cur = h_rdata;
    end
    for (int k = 0; k < HIST - 1; k++) begin
      new_row[k] = row_cur[k + 1];
    end
    new_row[HIST-1] = s2_x_r;
  end

  // Write back the row, or zeros during the clearing pass
  always_comb begin
    h_we    = clr_active_r || (adv && s2_valid_r);
    h_waddr = clr_active_r ? clr_addr_r : AW'(s2_ch_r);
    h_wdata = clr_active_r ? '0 : new_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (adv && s2_valid_r) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      fwd_ch_r  <= s2_ch_r;
      fwd_row_r <= new_row;
    end
  end

  // Multiply every tap in parallel, current sample on the last tap
  always_comb begin
    logic signed [SAMPLE_BITS-1:0] taps_x [TAPS];
    for (int k = 0; k < HIST; k++) begin
      taps_x[k] = $signed(row_cur[k]);
    end
    taps_x[TAPS-1] = $signed(s2_x_r);
    for (int k = 0; k < TAPS; k++) begin
      prod_nxt[k] = PW'(taps_x[k]) * PW'($signed(w_rdata[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ch_r <= s2_ch_r;
      s3_x_r  <= s2_x_r;
      prod_r  <= prod_nxt;
    end
  end

  // First tree level: sum products in groups
  always_comb begin
    logic signed [PW-1:0] prod_pad [PAD];
    for (int i = 0; i < PAD; i++) begin
      prod_pad[i] = '0;
    end
    for (int i = 0; i < TAPS; i++) begin
      prod_pad[i] = prod_r[i];
    end
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        grp_nxt[g] = grp_nxt[g] + GW'(prod_pad[g * GROUP_SIZE + j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ch_r <= s3_ch_r;
      s4_x_r  <= s3_x_r;
      grp_r   <= grp_nxt;
    end
  end

  // Add groups and residual, round half up, saturate
  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic signed [QW-1:0]    q;
    acc = (ACC_W'($signed(s4_x_r)) <<< FRAC_SHIFT) + ROUND;
    for (int g = 0; g < NGRP; g++) begin
      acc = acc + ACC_W'(grp_r[g]);
    end
    q = $signed(acc[ACC_W-1:FRAC_SHIFT]);
    if (q > QMAX) begin
      res_nxt = QMAX[SAMPLE_BITS-1:0];
      sat_nxt = 1'b1;
    end else if (q < QMIN) begin
      res_nxt = QMIN[SAMPLE_BITS-1:0];
      sat_nxt = 1'b1;
    end else begin
      res_nxt = q[SAMPLE_BITS-1:0];
      sat_nxt = 1'b0;
    end
  end

  // Output register, holds while the result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_val_r <= res_nxt;
      out_ch_r  <= s4_ch_r;
      out_sat_r <= sat_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_val_r;
  assign out_chan           = out_ch_r;
  assign out_saturated      = out_sat_r;

endmodule

// File: hdl/streaming_depthwise_fir_residual.sv
// ----------------------------------------------------------------------------
// streaming_depthwise_fir_residual: per-channel FIR bank with residual add
// Top level: front queue and execution pipeline.
// ----------------------------------------------------------------------------
// The block takes one item per clock while its output is not stalled. A load
// item writes one tap weight of one channel; a sample item returns, from the
// output register, the sample plus the sum of the channel's weights times
// its last TAPS samples, rounded to Q15.0 and saturated. Loads and items
// with an out-of-range channel give no result. The one-item-per-clock figure
// is set by one read of the channel's history row and one read of each
// weight lane per cycle, with all tap multiplies in parallel. After reset a
// clearing pass zeroes the history, one channel a cycle, over all CHANNELS
// channels (512 by default), during which in_ready stays low. Weights must
// be loaded before the first sample of a channel. A waiting result does not
// block the input: items keep entering the front queue until it fills.
// ----------------------------------------------------------------------------
module streaming_depthwise_fir_residual import sdfr_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int TAPS        = TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [CH_W-1:0]               in_chan,
  input  logic [TAP_W-1:0]              in_tap,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_value,
  input  logic signed [WEIGHT_BITS-1:0] in_weight_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_filtered_value,
  output logic [CH_W-1:0]               out_chan,
  output logic                          out_saturated
);

  localparam int DATA_W = (SAMPLE_BITS > WEIGHT_BITS) ? SAMPLE_BITS : WEIGHT_BITS;

  logic              clearing;
  logic              q_valid;
  logic              q_pop;
  item_ctl_t         q_ctl;
  logic [DATA_W-1:0] q_data;
  logic [SAMPLE_BITS-1:0] result;

  sdfr_front #(
    .CHANNELS    (CHANNELS),
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_chan         (in_chan),
    .in_tap          (in_tap),
    .in_sample_value (in_sample_value),
    .in_weight_value (in_weight_value),
    .clearing        (clearing),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_ctl           (q_ctl),
    .q_data          (q_data)
  );

  sdfr_back #(
    .CHANNELS    (CHANNELS),
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .clearing           (clearing),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .q_ctl              (q_ctl),
    .q_data             (q_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_value (result),
    .out_chan           (out_chan),
    .out_saturated      (out_saturated)
  );

  assign out_filtered_value = $signed(result);

endmodule

// File: hdl/sdfr_checker.sv
// ----------------------------------------------------------------------------
// sdfr_checker: port-level assertions of the FIR bank
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module sdfr_checker import sdfr_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_filtered_value,
  input logic [CH_W-1:0]        out_chan,
  input logic                   out_saturated
);

  localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // A clipped result sits on one of the range limits
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_filtered_value == SMAX) || (out_filtered_value == SMIN))
    else $error("saturated result is not at a range limit");

  // Clearing pass holds the input off and no result appears right after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready && !out_valid)
    else $error("activity right after reset");

  // Results only for channels that exist
  a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_chan) < CHANNELS))
    else $error("result for an out-of-range channel");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_filtered_value) && $stable(out_chan) &&
      $stable(out_saturated))
    else $error("stalled result changed");

endmodule

bind streaming_depthwise_fir_residual sdfr_checker #(
  .CHANNELS    (CHANNELS),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_sdfr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_filtered_value (out_filtered_value),
  .out_chan           (out_chan),
  .out_saturated      (out_saturated)
);

// File: tb/fir_bank_checker.sv
// ----------------------------------------------------------------------------
// fir_bank_checker: scoreboard of the depthwise FIR bank
// Watches all channels, keeps its own copy of the tap weights and sample
// history, predicts each filtered result and compares it field by field.
// ----------------------------------------------------------------------------
module fir_bank_checker import sdfr_pkg::*; (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              in_req_type,
  input  logic [CH_W-1:0]                   in_chan,
  input  logic [TAP_W-1:0]                  in_tap,
  input  logic signed [SAMPLE_BITS_DEF-1:0] in_sample_value,
  input  logic signed [WEIGHT_BITS-1:0]     in_weight_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [SAMPLE_BITS_DEF-1:0] out_filtered_value,
  input  logic [CH_W-1:0]                   out_chan,
  input  logic                              out_saturated,
  output int                                fail_count,
  output int                                pending,
  output int                                result_count,
  output int                                clip_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS = CHANNELS_DEF;
  localparam int TAPS     = TAPS_DEF;
  localparam int SB       = SAMPLE_BITS_DEF;
  localparam int HIST     = TAPS - 1;

  typedef struct packed {
    logic signed [SB-1:0] value;
    logic [CH_W-1:0]      channel;
    logic                 clipped;
  } fir_result_t;

  logic signed [WEIGHT_BITS-1:0] tap_weight [CHANNELS][TAPS];
  logic signed [SB-1:0]          history    [CHANNELS][HIST];
  fir_result_t                   expected_results [$];

  // Print the first few mismatches only, but count every one
  task automatic report_mismatch(input string msg);
    if (fail_count < 40) $display("%0t ns  mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Residual plus FIR sum over the channel's history, rounded half up to
  // Q15.0 and clipped to the sample range
  function automatic fir_result_t filter_sample(input logic [CH_W-1:0] ch,
                                                input logic signed [SB-1:0] x);
    longint      acc;
    longint      q;
    longint      smax;
    int          k;
    fir_result_t r;
    smax = (longint'(1) <<< (SB - 1)) - 1;
    acc  = longint'(x) * longint'(tap_weight[ch][TAPS-1]);
    for (k = 0; k < HIST; k++)
      acc += longint'(history[ch][k]) * longint'(tap_weight[ch][k]);
    acc += longint'(x) <<< FRAC_SHIFT;
    q = (acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    r.clipped = 1'b0;
    if (q > smax) begin
      q = smax;
      r.clipped = 1'b1;
    end else if (q < -smax - 1) begin
      q = -smax - 1;
      r.clipped = 1'b1;
    end
    r.value   = q[SB-1:0];
    r.channel = ch;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    fir_result_t want;
    int          c;
    int          k;
    if (!rst_n) begin
      // Clear history and weights: a new stream starts
      for (c = 0; c < CHANNELS; c++) begin
        for (k = 0; k < HIST; k++) history[c][k] = '0;
        for (k = 0; k < TAPS; k++) tap_weight[c][k] = '0;
      end
      expected_results.delete();
    end else begin
      // Compare the accepted result with the oldest prediction
      if (out_valid && out_ready) begin
        result_count++;
        if (out_saturated) clip_count++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %0d channel %0d",
                                    out_filtered_value, out_chan));
        end else begin
          want = expected_results.pop_front();
          if (out_filtered_value !== want.value)
            report_mismatch($sformatf("channel %0d value got %0d want %0d",
                                      want.channel, out_filtered_value, want.value));
          if (out_chan !== want.channel)
            report_mismatch($sformatf("channel got %0d want %0d",
                                      out_chan, want.channel));
          if (out_saturated !== want.clipped)
            report_mismatch($sformatf("channel %0d saturated got %0b want %0b",
                                      want.channel, out_saturated, want.clipped));
        end
      end
      // Predict from the accepted item; drop out-of-range channels and load taps
      if (in_valid && in_ready && in_chan < CHANNELS) begin
        if (req_t'(in_req_type) == REQ_LOAD) begin
          if (in_tap < TAPS) tap_weight[in_chan][in_tap] = in_weight_value;
        end else begin
          expected_results.push_back(filter_sample(in_chan, in_sample_value));
          for (k = 0; k < HIST - 1; k++)
            history[in_chan][k] = history[in_chan][k+1];
          history[in_chan][HIST-1] = in_sample_value;
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top of the depthwise FIR bank test
// Loads per-channel tap weights and streams samples through the block under
// several sender idle and receiver stall mixes, with a long output hold-off
// and a full drain; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench import sdfr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS    = CHANNELS_DEF;
  localparam int TAPS        = TAPS_DEF;
  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int ITEM_TARGET = 1950;
  localparam int LONG_HOLD   = 400;

  logic                          clk;
  logic                          rst_n           = 1'b0;
  logic                          in_valid        = 1'b0;
  logic                          in_ready;
  logic                          in_req_type     = 1'b0;
  logic [CH_W-1:0]               in_chan         = '0;
  logic [TAP_W-1:0]              in_tap          = '0;
  logic signed [SB-1:0]          in_sample_value = '0;
  logic signed [WEIGHT_BITS-1:0] in_weight_value = '0;
  logic                          out_valid;
  logic                          out_ready       = 1'b0;
  logic signed [SB-1:0]          out_filtered_value;
  logic [CH_W-1:0]               out_chan;
  logic                          out_saturated;

  int fails;
  int pending;
  int result_count;
  int clip_count;

  // Stimulus knobs shared with the receiver process
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_orders   = 0;

  int sent_loads    = 0;
  int sent_samples  = 0;
  int sent_ignored  = 0;
  bit is_live [CHANNELS];
  int live_channels [$];

  streaming_depthwise_fir_residual u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_chan            (in_chan),
    .in_tap             (in_tap),
    .in_sample_value    (in_sample_value),
    .in_weight_value    (in_weight_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_value (out_filtered_value),
    .out_chan           (out_chan),
    .out_saturated      (out_saturated)
  );

  fir_bank_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_chan            (in_chan),
    .in_tap             (in_tap),
    .in_sample_value    (in_sample_value),
    .in_weight_value    (in_weight_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_value (out_filtered_value),
    .out_chan           (out_chan),
    .out_saturated      (out_saturated),
    .fail_count         (fails),
    .pending            (pending),
    .result_count       (result_count),
    .clip_count         (clip_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is ordered
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_orders) begin
        hold_seen = hold_orders;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input req_t req, input logic [CH_W-1:0] ch,
                           input logic [TAP_W-1:0] tap,
                           input logic signed [SB-1:0] smp,
                           input logic signed [WEIGHT_BITS-1:0] wgt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_chan         <= ch;
    in_tap          <= tap;
    in_sample_value <= smp;
    in_weight_value <= wgt;
    do @(posedge clk); while (!in_ready);
    if (req == REQ_SAMPLE) sent_samples++;
    else if (tap < TAPS) sent_loads++;
    else sent_ignored++;
  endtask

  // Stop offering and wait until every predicted result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic signed [WEIGHT_BITS-1:0] random_weight(input int cls);
    logic signed [WEIGHT_BITS-1:0] w;
    case (cls)
      0: w = 16'($urandom);
      1: w = 16'(int'($urandom_range(512)) - 256);
      default: begin
        case ($urandom_range(5))
          0: w = 16'sh7FFF;
          1: w = 16'sh8000;
          2: w = 16'sd1;
          3: w = -16'sd1;
          4: w = 16'sd8192;
          default: w = '0;
        endcase
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [SB-1:0] random_sample();
    logic signed [SB-1:0] s;
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) s = 16'($urandom);
    else if (pick < 85) s = 16'(int'($urandom_range(4096)) - 2048);
    else begin
      case ($urandom_range(5))
        0: s = 16'sh7FFF;
        1: s = 16'sh8000;
        2: s = 16'sd1;
        3: s = -16'sd1;
        4: s = 16'sd1024;
        default: s = '0;
      endcase
    end
    return s;
  endfunction

  // Write all taps of a channel in shuffled order, then mark it usable
  task automatic load_channel(input logic [CH_W-1:0] ch, input int cls);
    int order [TAPS];
    int i;
    int j;
    int t;
    for (i = 0; i < TAPS; i++) order[i] = i;
    for (i = TAPS - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (i = 0; i < TAPS; i++)
      send_item(REQ_LOAD, ch, TAP_W'(order[i]), 16'($urandom), random_weight(cls));
    if (!is_live[ch]) begin
      is_live[ch] = 1'b1;
      live_channels.push_back(int'(ch));
    end
  endtask

  initial begin : stimulus
    int   t;
    int   pick;
    int   burst;
    int   phase;
    bit   held_once;
    bit   paused_once;
    logic [CH_W-1:0] ch;
    held_once   = 1'b0;
    paused_once = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme weights on the top channel, ignored taps, rounding
    // of an exact half, clipping at both ends, and a weight reload
    for (t = 0; t < TAPS; t++) begin
      case (t)
        0:        send_item(REQ_LOAD, 9'd511, TAP_W'(t), 16'sh0, 16'sh7FFF);
        TAPS - 2: send_item(REQ_LOAD, 9'd511, TAP_W'(t), 16'sh0, 16'sh8000);
        TAPS - 1: send_item(REQ_LOAD, 9'd511, TAP_W'(t), 16'sh0, 16'sd1);
        default:  send_item(REQ_LOAD, 9'd511, TAP_W'(t), 16'sh0, 16'sh0);
      endcase
    end
    is_live[511] = 1'b1;
    live_channels.push_back(511);
    send_item(REQ_LOAD, 9'd0, 4'd11, 16'sh7FFF, 16'sh7FFF);
    send_item(REQ_LOAD, 9'd511, 4'd15, 16'sh8000, 16'sh8000);
    send_item(REQ_SAMPLE, 9'd511, 4'd15, 16'sd4096, 16'sh7FFF);
    send_item(REQ_SAMPLE, 9'd511, 4'd0, -16'sd4096, 16'sh8000);
    send_item(REQ_SAMPLE, 9'd511, 4'd3, 16'sh7FFF, 16'sh0);
    send_item(REQ_SAMPLE, 9'd511, 4'd3, 16'sh7FFF, 16'sh0);
    send_item(REQ_SAMPLE, 9'd511, 4'd7, 16'sh8000, 16'shFFFF);
    send_item(REQ_SAMPLE, 9'd511, 4'd7, 16'sh8000, 16'shFFFF);
    send_item(REQ_SAMPLE, 9'd511, 4'd0, 16'sh0, 16'sh0);
    send_item(REQ_SAMPLE, 9'd511, 4'd0, -16'sd1, 16'sh0);
    send_item(REQ_LOAD, 9'd511, TAP_W'(TAPS - 1), 16'sh0, 16'sh8000);
    send_item(REQ_SAMPLE, 9'd511, 4'd10, 16'sh7FFF, 16'sh0);

    // Random: mostly sample bursts on loaded channels, with channel setup,
    // single weight reloads and ignored loads mixed in
    while (sent_loads + sent_samples < ITEM_TARGET) begin
      phase = (sent_loads + sent_samples) * 4 / ITEM_TARGET;
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 59; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase

      // Hold the output long enough for the block to back up into its input
      if (!held_once && phase == 0 && sent_samples > 150) begin
        held_once = 1'b1;
        hold_orders++;
      end
      // Pause the sender once until everything in flight has come out
      if (!paused_once && phase == 2) begin
        paused_once = 1'b1;
        wait_drained();
      end

      pick = $urandom_range(99);
      if (live_channels.size() < 3 || (pick < 4 && live_channels.size() < 24)) begin
        load_channel(CH_W'($urandom_range(CHANNELS - 1)), $urandom_range(2));
      end else if (pick < 16) begin
        ch = CH_W'(live_channels[$urandom_range(live_channels.size() - 1)]);
        send_item(REQ_LOAD, ch, TAP_W'($urandom_range(TAPS - 1)), 16'($urandom),
                  random_weight($urandom_range(2)));
      end else if (pick < 24) begin
        send_item(REQ_LOAD, CH_W'($urandom), TAP_W'($urandom_range(15, TAPS)),
                  16'($urandom), 16'($urandom));
      end else begin
        burst = $urandom_range(1, 8);
        ch    = CH_W'(live_channels[$urandom_range(live_channels.size() - 1)]);
        repeat (burst) begin
          if ($urandom_range(99) < 30)
            ch = CH_W'(live_channels[$urandom_range(live_channels.size() - 1)]);
          send_item(REQ_SAMPLE, ch, TAP_W'($urandom), random_sample(), 16'($urandom));
        end
      end
    end

    // Drain, then give stray results time to show up
    wait_drained();
    repeat (50) @(posedge clk);

    $display("Sent %0d weight loads, %0d samples and %0d ignored loads on %0d channels.",
             sent_loads, sent_samples, sent_ignored, live_channels.size());
    $display("Compared %0d results (%0d clipped) across four idle/stall mixes: %0d errors.",
             result_count, clip_count, fails);
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
